// ===== rtl/kcc_pkg.sv =====
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared types and codes for the key click classifier.
// ----------------------------------------------------------------------------
package kcc_pkg;

    // Per-key press phase
    typedef enum logic [2:0] {
        PH_IDLE         = 3'd0,
        PH_PRESSED      = 3'd1,
        PH_LONG_HELD    = 3'd2,
        PH_WAIT_SECOND  = 3'd3,
        PH_SECOND_PRESS = 3'd4
    } phase_t;

    // Latched key event codes
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_LONG   = 2'd2,
        EV_DOUBLE = 2'd3
    } click_event_t;

    // Item kinds carried in s_tuser
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS   = 2'd1;
    localparam logic [1:0] REG_DOUBLE_CLICK = 2'd2;

    localparam int CFG_W = 16;

    // Timing thresholds in ms
    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] long_press;
        logic [CFG_W-1:0] double_click;
    } timing_cfg_t;

    // Per-lane strobes for one accepted item
    typedef struct packed {
        logic scan;
        logic clear;
    } lane_ctrl_t;

endpackage

// ===== rtl/kcc_lane.sv =====
// ----------------------------------------------------------------------------
// kcc_lane
// One key: five-phase press machine, time stamps and latched event.
// ----------------------------------------------------------------------------
module kcc_lane
    import kcc_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lane_ctrl_t           ctrl,
    input  logic                 level,
    input  logic [TIME_BITS-1:0] now,
    input  timing_cfg_t          cfg,
    output click_event_t         pending
);

    phase_t               phase_reg, phase_next;
    click_event_t         pending_reg, pending_next;
    logic [TIME_BITS-1:0] press_stamp_reg, press_stamp_next;
    logic [TIME_BITS-1:0] release_stamp_reg, release_stamp_next;
    logic [TIME_BITS-1:0] press_el;
    logic [TIME_BITS-1:0] release_el;

    // wrapping differences
    assign press_el   = now - press_stamp_reg;
    assign release_el = now - release_stamp_reg;

    always_comb begin
        phase_next         = phase_reg;
        pending_next       = pending_reg;
        press_stamp_next   = press_stamp_reg;
        release_stamp_next = release_stamp_reg;
        if (ctrl.clear) begin
            pending_next = EV_NONE;
        end
        if (ctrl.scan) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (level) begin
                        press_stamp_next = now;
                        phase_next       = PH_PRESSED;
                    end
                end
                PH_PRESSED: begin
                    if (!level) begin
                        if (press_el < TIME_BITS'(cfg.debounce)) begin
                            phase_next = PH_IDLE;
                        end else begin
                            release_stamp_next = now;
                            phase_next         = PH_WAIT_SECOND;
                        end
                    end else if (press_el >= TIME_BITS'(cfg.long_press)) begin
                        pending_next = EV_LONG;
                        phase_next   = PH_LONG_HELD;
                    end
                end
                PH_LONG_HELD: begin
                    if (!level) begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_WAIT_SECOND: begin
                    if (level) begin
                        press_stamp_next = now;
                        phase_next       = PH_SECOND_PRESS;
                    end else if (release_el >= TIME_BITS'(cfg.double_click)) begin
                        pending_next = EV_SHORT;
                        phase_next   = PH_IDLE;
                    end
                end
                PH_SECOND_PRESS: begin
                    if (!level) begin
                        pending_next = EV_DOUBLE;
                        phase_next   = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            pending_reg <= EV_NONE;
        end else begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
        end
    end

    // stamps are always written before they are read
    always_ff @(posedge aclk) begin
        press_stamp_reg   <= press_stamp_next;
        release_stamp_reg <= release_stamp_next;
    end

    assign pending = pending_reg;

endmodule

// ===== rtl/kcc_merge.sv =====
// ----------------------------------------------------------------------------
// kcc_merge
// Picks the addressed key's event on a read and holds it in the output register.
// ----------------------------------------------------------------------------
module kcc_merge
    import kcc_pkg::*;
#(
    parameter int KEYS = 4,
    parameter int ID_W = 2
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    rd_fire,
    input  logic [ID_W-1:0]         key_id,
    input  click_event_t [KEYS-1:0] events,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output click_event_t            key_event
);

    logic         valid_reg, valid_next;
    click_event_t event_reg, event_next;
    logic         key_ok;
    click_event_t sel_event;

    assign key_ok = ({1'b0, key_id} < (ID_W+1)'(KEYS));

    always_comb begin
        sel_event = EV_NONE;
        for (int k = 0; k < KEYS; k++) begin
            if (key_id == ID_W'(k)) begin
                sel_event = events[k];
            end
        end
        if (!key_ok) begin
            sel_event = EV_NONE;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        event_next = event_reg;
        if (rd_fire) begin
            valid_next = 1'b1;
            event_next = sel_event;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        event_reg <= event_next;
    end

    assign m_tvalid  = valid_reg;
    assign key_event = event_reg;

endmodule

// ===== rtl/key_click_classifier.sv =====
// ----------------------------------------------------------------------------
// key_click_classifier
// Short / long / double press classifier for a bank of keys.
// ----------------------------------------------------------------------------
//
//  channel  | ports                       | carries
//  ---------+-----------------------------+--------------------------------------
//  s_       | s_tvalid s_tready s_tdata   | scan tick or event read
//           | s_tuser                     |   (tuser = op)
//  m_       | m_tvalid m_tready m_tdata   | key event, one per read item
//  cfg_     | cfg_we cfg_addr cfg_data    | debounce / long press / double window
//
//  One item per cycle while s_tready is high. A scan updates every key lane
//  in the cycle it is accepted; a read picks the key's event in the same
//  cycle and registers it, so m_tvalid rises in the cycle after the read.
//  s_tready is low only while a result waits and m_tready is low.
//  aresetn is synchronous, active low: all keys idle, no events, timing
//  registers back to 20 / 1000 / 300 ms.
// ----------------------------------------------------------------------------
module key_click_classifier
    import kcc_pkg::*;
#(
    parameter int KEYS      = 4,
    parameter int TIME_BITS = 32
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // s_tdata: key_levels[KEYS], now_ms[32], key_id[ID_W], zero fill
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [((KEYS+32+((KEYS > 1) ? $clog2(KEYS) : 1)+7)/8)*8-1:0] s_tdata,
    // s_tuser: op
    input  logic                                        s_tuser,
    // m_tdata: key_event[2], zero fill
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [7:0]                                  m_tdata,
    input  logic                                        cfg_we,
    input  logic [1:0]                                  cfg_addr,
    input  logic [CFG_W-1:0]                            cfg_data
);

    localparam int ID_W    = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int NOW_LSB = KEYS;
    localparam int ID_LSB  = KEYS + 32;

    logic [KEYS-1:0]         key_levels;
    logic [31:0]             now_ms;
    logic [ID_W-1:0]         key_id;
    logic [TIME_BITS-1:0]    now_t;
    logic                    in_fire;
    logic                    scan_fire;
    logic                    rd_fire;
    timing_cfg_t             cfg_reg, cfg_next;
    click_event_t [KEYS-1:0] events;
    click_event_t            key_event;

    // field unpack
    assign key_levels = s_tdata[KEYS-1:0];
    assign now_ms     = s_tdata[NOW_LSB+31:NOW_LSB];
    assign key_id     = s_tdata[ID_LSB+ID_W-1:ID_LSB];
    assign now_t      = now_ms[TIME_BITS-1:0];

    // the output register frees up as soon as the consumer takes it
    assign s_tready  = !m_tvalid || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign scan_fire = in_fire && (s_tuser == OP_SCAN);
    assign rd_fire   = in_fire && (s_tuser == OP_READ);

    // timing registers; unknown index is ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_DEBOUNCE:     cfg_next.debounce     = cfg_data;
                REG_LONG_PRESS:   cfg_next.long_press   = cfg_data;
                REG_DOUBLE_CLICK: cfg_next.double_click = cfg_data;
                default:          cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce     <= CFG_W'(20);
            cfg_reg.long_press   <= CFG_W'(1000);
            cfg_reg.double_click <= CFG_W'(300);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // one lane per key
    for (genvar k = 0; k < KEYS; k++) begin : g_lane
        lane_ctrl_t ctrl;

        assign ctrl.scan  = scan_fire;
        assign ctrl.clear = rd_fire && (key_id == ID_W'(k));

        kcc_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .level   (key_levels[k]),
            .now     (now_t),
            .cfg     (cfg_reg),
            .pending (events[k])
        );
    end

    kcc_merge #(
        .KEYS (KEYS),
        .ID_W (ID_W)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_fire   (rd_fire),
        .key_id    (key_id),
        .events    (events),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .key_event (key_event)
    );

    assign m_tdata = {6'b0, key_event};

endmodule

// ===== dv/key_click_classifier_tb.sv =====
// ----------------------------------------------------------------------------
// key_click_classifier_tb
// Self-checking bench for the short / long / double press classifier.
// Drives scan and read items on the input stream, predicts every read's
// key event from a behavioral copy of the per-key press machines, and
// compares each m_ item with the oldest predicted event. Runs a directed
// sequence, then random phases over several timing settings and idle mixes.
// ----------------------------------------------------------------------------
module key_click_classifier_tb;
    import kcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEYS          = 4;
    localparam int ID_W          = 2;
    localparam int TDATA_W       = ((KEYS + 32 + ID_W + 7) / 8) * 8;
    localparam int PHASE_ITEMS   = 88;
    localparam int SETTLE_CYCLES = 4;       // settle margin after the last item
    localparam int CYCLE_LIMIT   = 300000;

    // ------------------------------------------------------------------------
    // Press classifier predictor: timing registers, per-key machines,
    // and the queue of key events still owed by the block.
    // ------------------------------------------------------------------------
    class key_event_predictor;
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] double_click_ms;
        phase_t           phase    [KEYS];
        logic [31:0]      press_at [KEYS];
        logic [31:0]      release_at [KEYS];
        click_event_t     latched  [KEYS];
        click_event_t     owed_events [$];
        int               mismatches;

        function new();
            debounce_ms     = 16'd20;
            long_press_ms   = 16'd1000;
            double_click_ms = 16'd300;
            for (int k = 0; k < KEYS; k++) begin
                phase[k]      = PH_IDLE;
                press_at[k]   = '0;
                release_at[k] = '0;
                latched[k]    = EV_NONE;
            end
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_DEBOUNCE:     debounce_ms     = value;
                REG_LONG_PRESS:   long_press_ms   = value;
                REG_DOUBLE_CLICK: double_click_ms = value;
                default: ;
            endcase
        endfunction

        // one key's machine for one scan; time differences wrap at 2^32
        function void scan_key(int k, logic pressed, logic [31:0] now);
            logic [31:0] held;
            logic [31:0] gap;
            held = now - press_at[k];
            gap  = now - release_at[k];
            case (phase[k])
                PH_IDLE: begin
                    if (pressed) begin
                        press_at[k] = now;
                        phase[k]    = PH_PRESSED;
                    end
                end
                PH_PRESSED: begin
                    if (!pressed) begin
                        if (held < 32'(debounce_ms)) begin
                            phase[k] = PH_IDLE;             // bounce, dropped
                        end else begin
                            release_at[k] = now;
                            phase[k]      = PH_WAIT_SECOND;
                        end
                    end else if (held >= 32'(long_press_ms)) begin
                        latched[k] = EV_LONG;
                        phase[k]   = PH_LONG_HELD;
                    end
                end
                PH_LONG_HELD: begin
                    if (!pressed) phase[k] = PH_IDLE;
                end
                PH_WAIT_SECOND: begin
                    if (pressed) begin
                        press_at[k] = now;
                        phase[k]    = PH_SECOND_PRESS;
                    end else if (gap >= 32'(double_click_ms)) begin
                        latched[k] = EV_SHORT;
                        phase[k]   = PH_IDLE;
                    end
                end
                PH_SECOND_PRESS: begin
                    // second press is not debounced
                    if (!pressed) begin
                        latched[k] = EV_DOUBLE;
                        phase[k]   = PH_IDLE;
                    end
                end
                default: phase[k] = PH_IDLE;
            endcase
        endfunction

        // note one accepted input item
        function void note_item(logic op, logic [KEYS-1:0] levels, logic [31:0] now,
                                logic [ID_W-1:0] id);
            if (op == OP_SCAN) begin
                for (int k = 0; k < KEYS; k++) scan_key(k, levels[k], now);
            end else begin
                owed_events.push_back(latched[id]);
                latched[id] = EV_NONE;
            end
        endfunction

        // check one accepted result item against the oldest owed event
        function void check_event(click_event_t got);
            click_event_t want;
            if (owed_events.size() == 0) begin
                $display("%0t: key event with none owed: expected nothing, actual %0d",
                         $time, got);
                mismatches++;
            end else begin
                want = owed_events.pop_front();
                if (got !== want) begin
                    $display("%0t: key_event mismatch: expected %0d, actual %0d",
                             $time, want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT connections; every input known from time zero
    // ------------------------------------------------------------------------
    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    // s_tdata: key_levels[4], now_ms[32], key_id[2], zero fill
    logic [TDATA_W-1:0] s_tdata  = '0;
    // s_tuser: op
    logic               s_tuser  = OP_SCAN;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // m_tdata: key_event[2], zero fill
    logic [7:0]         m_tdata;
    logic               cfg_we   = 1'b0;
    logic [1:0]         cfg_addr = REG_DEBOUNCE;
    logic [CFG_W-1:0]   cfg_data = '0;

    key_click_classifier #(
        .KEYS      (KEYS),
        .TIME_BITS (32)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    key_event_predictor clicks = new();

    int               send_idle_pct  = 0;   // chance of a gap before each item
    int               recv_stall_pct = 0;   // chance m_tready is low per cycle
    int               cycle_count    = 0;
    logic [KEYS-1:0]  scan_levels    = '0;  // key levels carried between scans
    logic [31:0]      scan_now       = '0;  // running millisecond clock

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: check each accepted event, then pick next cycle's m_tready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            clicks.check_event(click_event_t'(m_tdata[1:0]));
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Drive one item; returns at the edge where it is accepted.
    // s_tvalid stays high from one item to the next unless a gap is taken.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [KEYS-1:0] levels,
                             input logic [31:0] now, input logic [ID_W-1:0] id);
        logic [TDATA_W-1:0] word;
        word = '0;
        word[KEYS-1:0]                 = levels;
        word[KEYS+31:KEYS]             = now;
        word[KEYS+32+ID_W-1:KEYS+32]   = id;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        clicks.note_item(op, levels, now, id);
    endtask

    // stop sending and wait until every owed event has come out
    task automatic drain_events();
        s_tvalid <= 1'b0;
        while (clicks.owed_events.size() != 0) @(posedge aclk);
        // scans leave no result; let the last one settle before any write
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write all three timing registers; only called while the block is idle
    task automatic write_timing(input logic [CFG_W-1:0] debounce,
                                input logic [CFG_W-1:0] long_press,
                                input logic [CFG_W-1:0] double_click);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_DEBOUNCE;
        cfg_data <= debounce;
        @(posedge aclk);
        cfg_addr <= REG_LONG_PRESS;
        cfg_data <= long_press;
        @(posedge aclk);
        cfg_addr <= REG_DOUBLE_CLICK;
        cfg_data <= double_click;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        clicks.write_reg(REG_DEBOUNCE, debounce);
        clicks.write_reg(REG_LONG_PRESS, long_press);
        clicks.write_reg(REG_DOUBLE_CLICK, double_click);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: mostly scans whose levels toggle key by key, so presses,
    // releases and second clicks form real sequences; time steps are scaled
    // to the current thresholds so every phase boundary is hit from both sides.
    // ------------------------------------------------------------------------
    task automatic run_random(input int count);
        int unsigned span;
        int unsigned pick;
        logic [KEYS-1:0] flip;
        span = 32'(clicks.debounce_ms);
        if (32'(clicks.long_press_ms) > span) span = 32'(clicks.long_press_ms);
        if (32'(clicks.double_click_ms) > span) span = 32'(clicks.double_click_ms);
        span = span + 1;
        scan_now = $urandom;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 30) begin
                // read; levels and time are don't-care here
                send_item(OP_READ, KEYS'($urandom), $urandom,
                          ID_W'($urandom_range(KEYS - 1)));
            end else begin
                pick = $urandom_range(99);
                if (pick < 5)
                    scan_now = $urandom;                        // time jump noise
                else if (pick < 40)
                    scan_now = scan_now + $urandom_range(3);
                else if (pick < 75)
                    scan_now = scan_now + $urandom_range(span / 2 + 1);
                else
                    scan_now = scan_now + $urandom_range(span + span / 2);
                if ($urandom_range(99) < 10) begin
                    scan_levels = KEYS'($urandom);
                end else begin
                    for (int k = 0; k < KEYS; k++)
                        flip[k] = ($urandom_range(99) < 30);
                    scan_levels = scan_levels ^ flip;
                end
                send_item(OP_SCAN, scan_levels, scan_now, ID_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset timing 20 / 1000 / 300 ms
        send_item(OP_SCAN, 4'b0000, 32'd0, 2'd0);
        send_item(OP_SCAN, 4'b1111, 32'd100, 2'd0);     // all keys down
        send_item(OP_SCAN, 4'b1110, 32'd110, 2'd0);     // key 0 bounce, dropped
        send_item(OP_SCAN, 4'b1100, 32'd130, 2'd0);     // key 1 valid release
        send_item(OP_SCAN, 4'b1110, 32'd200, 2'd0);     // key 1 second press
        send_item(OP_SCAN, 4'b1000, 32'd205, 2'd0);     // key 1 double, key 2 released
        send_item(OP_SCAN, 4'b1000, 32'd1100, 2'd0);    // key 2 short, key 3 long
        send_item(OP_READ, 4'b0000, 32'd0, 2'd0);
        send_item(OP_READ, 4'b0000, 32'd0, 2'd1);
        send_item(OP_READ, 4'b0000, 32'd0, 2'd2);
        send_item(OP_READ, 4'b0000, 32'd0, 2'd3);
        send_item(OP_READ, 4'b1111, 32'hFFFF_FFFF, 2'd3);   // cleared by last read
        send_item(OP_SCAN, 4'b0000, 32'd1200, 2'd0);    // long hold release: no event
        // unread short event replaced by a long one
        send_item(OP_SCAN, 4'b0001, 32'd2000, 2'd0);
        send_item(OP_SCAN, 4'b0000, 32'd2050, 2'd0);
        send_item(OP_SCAN, 4'b0000, 32'd2400, 2'd0);
        send_item(OP_SCAN, 4'b0001, 32'd2500, 2'd0);
        send_item(OP_SCAN, 4'b0001, 32'd3600, 2'd0);
        send_item(OP_READ, 4'b0000, 32'd0, 2'd0);
        // press spanning the time wrap
        send_item(OP_SCAN, 4'b0000, 32'hFFFF_FFF0, 2'd0);
        send_item(OP_SCAN, 4'b0010, 32'hFFFF_FFFF, 2'd0);
        send_item(OP_SCAN, 4'b0000, 32'h0000_0030, 2'd0);
        send_item(OP_SCAN, 4'b0000, 32'h0000_0200, 2'd0);
        send_item(OP_READ, 4'b0000, 32'd0, 2'd1);

        // random phases: timing setting and idle mix change together
        for (int p = 0; p < 6; p++) begin
            drain_events();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            case (p)
                0: write_timing(16'd0, 16'd0, 16'd0);
                1: write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: write_timing(16'd20, 16'd1000, 16'd300);
                3: write_timing(16'd5, 16'd60, 16'd30);
                4: write_timing(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
                default: write_timing(CFG_W'($urandom_range(100)),
                                      CFG_W'($urandom_range(2000)),
                                      CFG_W'($urandom_range(600)));
            endcase
            run_random(PHASE_ITEMS);
        end
        drain_events();

        if (clicks.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
